@@ rtl/rgbhsv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the RGB to HSV converter.
// No dependencies; every other file in rtl/ imports this package.
package rgbhsv_pkg;

    localparam int CH_W   = 8;   // channel width
    localparam int HUE_W  = 15;  // hue field width, 1/64 degree units
    localparam int HUE_QB = 12;  // hue quotient bits (quotient <= 3840)
    localparam int SAT_QB = 8;   // saturation quotient bits (quotient <= 255)
    localparam int HUE_NW = 20;  // hue dividend width: 3840 * 255 < 2**20
    localparam int SAT_NW = 16;  // saturation dividend width: 255 * 255 < 2**16

    localparam logic [HUE_W-1:0] HUE_TURN  = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_OFS_R = 15'd0;
    localparam logic [HUE_W-1:0] HUE_OFS_G = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_OFS_B = 15'd15360;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Classified pixel as it travels from the front end to the divider pipe.
    typedef struct packed {
        logic [HUE_NW-1:0] hue_num;  // 3840 * |difference|
        logic [CH_W-1:0]   delta;    // max - min, hue divisor
        logic [SAT_NW-1:0] sat_num;  // 255 * delta
        logic [CH_W-1:0]   mx;       // max, saturation divisor and value
        logic              neg;      // sector difference was negative
        t_sector           sector;
        logic              grey;     // max equals min
    } t_item;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic [HUE_W-1:0] sector_ofs(input t_sector sec);
        logic [HUE_W-1:0] ofs;
        case (sec)
            SEC_RED:   ofs = HUE_OFS_R;
            SEC_GREEN: ofs = HUE_OFS_G;
            SEC_BLUE:  ofs = HUE_OFS_B;
            default:   ofs = HUE_OFS_R;
        endcase
        return ofs;
    endfunction

endpackage

@@ rtl/rgb_to_hsv_convert.sv @@
`timescale 1ns / 1ps
// Top level of the RGB to HSV converter: front end, queue, divider pipe.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_fifo and rgbhsv_back.
//
//  channel   direction  handshake          word fields
//  -------   ---------  -----------------  ---------------------------------
//  pixel     in         start / busy       i_red, i_green, i_blue
//  result    out        o_done strobe      o_hue, o_saturation, o_brightness
//
// One pixel per clock, sustained. From the accepting edge to the edge that
// takes the result, a pixel passes one front register, one queue slot,
// twelve restoring divider stages (one hue quotient bit each; the eight
// saturation bits ride along in the first eight) and the output register.
// The twelve-bit hue quotient sets the number of divider stages.
// Reset is synchronous; busy stays high while i_rst_n is low.
// Results cannot be held off, so the divider pipe never stalls and the
// queue drains every cycle; busy drops as soon as reset is released.
module rgb_to_hsv_convert #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    output logic                          o_done,
    output logic [rgbhsv_pkg::HUE_W-1:0]  o_hue,
    output logic [7:0]                    o_saturation,
    output logic [7:0]                    o_brightness
);
    import rgbhsv_pkg::*;

    localparam int LAT = HUE_QB + 3;

    t_q_stat w_q_stat;
    t_item   w_push_item, w_head_item;
    logic    w_push, w_pop, w_accept;

    assign w_accept = start && !busy;

    // accept and classify the pixel
    rgbhsv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .i_q_stat (w_q_stat),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // decouple the front end from the divider pipe
    rgbhsv_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .W     ($bits(t_item))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_item),
        .i_pop   (w_pop),
        .o_rdata (w_head_item),
        .o_stat  (w_q_stat)
    );

    // divide, add the sector offset, wrap negative hue
    rgbhsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (w_q_stat),
        .i_item       (w_head_item),
        .o_pop        (w_pop),
        .o_done       (o_done),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    // every accepted word comes out as a result strobe
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept, LAT) |-> o_done)
        else $error("accepted pixel did not produce a result on time");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LAT))
        else $error("result strobe without a matching accepted pixel");

    // hue stays inside one turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hue < HUE_TURN))
        else $error("hue outside one full turn");

    // a black pixel has no saturation and no hue
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_brightness == '0)) |-> ((o_saturation == '0) && (o_hue == '0)))
        else $error("black pixel with nonzero hue or saturation");

endmodule

@@ rtl/rgbhsv_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts a pixel, finds max/min, picks the hue sector and
// builds both dividends. Depends on rgbhsv_pkg.
module rgbhsv_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [7:0]                 i_red,
    input  logic [7:0]                 i_green,
    input  logic [7:0]                 i_blue,
    input  rgbhsv_pkg::t_q_stat        i_q_stat,
    output logic                       o_busy,
    output logic                       o_push,
    output rgbhsv_pkg::t_item          o_item
);
    import rgbhsv_pkg::*;

    logic              r_valid, n_valid;
    t_item             r_item, n_item;
    logic              w_accept;
    logic [CH_W-1:0]   w_mx, w_mn, w_ad;
    logic [CH_W:0]     w_diff;
    t_sector           w_sec;

    assign o_push   = r_valid && !i_q_stat.full;
    assign o_busy   = !i_rst_n || (r_valid && i_q_stat.full);
    assign w_accept = i_start && !o_busy;
    assign o_item   = r_item;

    always_comb begin
        w_mx = i_red;
        w_mn = i_red;
        if (i_green > w_mx) w_mx = i_green;
        if (i_blue > w_mx)  w_mx = i_blue;
        if (i_green < w_mn) w_mn = i_green;
        if (i_blue < w_mn)  w_mn = i_blue;

        // red wins ties over green, green over blue
        if (i_red == w_mx) begin
            w_sec  = SEC_RED;
            w_diff = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green == w_mx) begin
            w_sec  = SEC_GREEN;
            w_diff = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            w_sec  = SEC_BLUE;
            w_diff = {1'b0, i_red} - {1'b0, i_green};
        end
        w_ad = w_diff[CH_W] ? CH_W'(-w_diff) : w_diff[CH_W-1:0];

        n_item.mx      = w_mx;
        n_item.delta   = w_mx - w_mn;
        n_item.grey    = (w_mx == w_mn);
        n_item.sector  = w_sec;
        n_item.neg     = w_diff[CH_W];
        // 3840 = 4096 - 256, 255 = 256 - 1
        n_item.hue_num = (HUE_NW'(w_ad) << 12) - (HUE_NW'(w_ad) << 8);
        n_item.sat_num = (SAT_NW'(n_item.delta) << 8) - SAT_NW'(n_item.delta);
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept)    n_valid = 1'b1;
        else if (o_push) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

@@ rtl/rgbhsv_fifo.sv @@
`timescale 1ns / 1ps
// Short queue between front end and divider pipe.
// Depends on rgbhsv_pkg for the status struct.
module rgbhsv_fifo #(
    parameter int DEPTH = 2,
    parameter int W     = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [W-1:0]        i_wdata,
    input  logic                i_pop,
    output logic [W-1:0]        o_rdata,
    output rgbhsv_pkg::t_q_stat o_stat
);
    import rgbhsv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_pop        = i_pop && (r_count != '0);
    assign o_stat.empty = (r_count == '0);
    // a slot frees up this cycle when the head is taken
    assign o_stat.full  = (r_count == CW'(DEPTH)) && !w_pop;
    assign o_rdata      = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd    = w_pop  ? ptr_inc(r_rd) : r_rd;
        n_count = r_count;
        if (i_push && !w_pop)      n_count = r_count + 1'b1;
        else if (!i_push && w_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

@@ rtl/rgbhsv_back.sv @@
`timescale 1ns / 1ps
// Back end: pipelined restoring dividers for hue and saturation, one
// quotient bit per stage, then sector offset and wrap. Depends on rgbhsv_pkg.
module rgbhsv_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rgbhsv_pkg::t_q_stat           i_q_stat,
    input  rgbhsv_pkg::t_item             i_item,
    output logic                          o_pop,
    output logic                          o_done,
    output logic [rgbhsv_pkg::HUE_W-1:0]  o_hue,
    output logic [7:0]                    o_saturation,
    output logic [7:0]                    o_brightness
);
    import rgbhsv_pkg::*;

    typedef struct packed {
        logic [HUE_NW-1:0] hrem;
        logic [HUE_QB-1:0] hq;
        logic [CH_W-1:0]   delta;
        logic [SAT_NW-1:0] srem;
        logic [SAT_QB-1:0] sq;
        logic [CH_W-1:0]   mx;
        logic              neg;
        t_sector           sector;
        logic              grey;
    } t_dstage;

    t_dstage          w_st  [0:HUE_QB];
    logic             w_vld [0:HUE_QB];
    t_dstage          r_st  [1:HUE_QB];
    logic             r_vld [1:HUE_QB];

    t_dstage          w_last;
    logic [HUE_W-1:0] w_q, w_base, n_hue;
    logic [7:0]       n_sat;
    logic             r_done;

    // the pipe never stalls: take the head whenever there is one
    assign o_pop = !i_q_stat.empty;

    always_comb begin
        w_st[0].hrem   = i_item.hue_num;
        w_st[0].hq     = '0;
        w_st[0].delta  = i_item.delta;
        w_st[0].srem   = i_item.sat_num;
        w_st[0].sq     = '0;
        w_st[0].mx     = i_item.mx;
        w_st[0].neg    = i_item.neg;
        w_st[0].sector = i_item.sector;
        w_st[0].grey   = i_item.grey;
    end
    assign w_vld[0] = !i_q_stat.empty;

    for (genvar s = 0; s < HUE_QB; s++) begin : g_stage
        localparam int KH   = HUE_QB - 1 - s;
        localparam int KS   = (s < SAT_QB) ? (SAT_QB - 1 - s) : 0;
        localparam bit DO_S = (s < SAT_QB);

        t_dstage           n_st;
        logic [HUE_NW-1:0] w_hdsh;
        logic [SAT_NW-1:0] w_sdsh;
        logic              w_hge, w_sge;

        assign w_st[s+1]  = r_st[s+1];
        assign w_vld[s+1] = r_vld[s+1];

        always_comb begin
            n_st   = w_st[s];
            w_hdsh = HUE_NW'(w_st[s].delta) << KH;
            w_hge  = (w_st[s].hrem >= w_hdsh);
            if (w_hge) n_st.hrem = w_st[s].hrem - w_hdsh;
            n_st.hq = {w_st[s].hq[HUE_QB-2:0], w_hge};

            w_sdsh = SAT_NW'(w_st[s].mx) << KS;
            w_sge  = (w_st[s].srem >= w_sdsh);
            if (DO_S) begin
                if (w_sge) n_st.srem = w_st[s].srem - w_sdsh;
                n_st.sq = {w_st[s].sq[SAT_QB-2:0], w_sge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[s+1] <= n_st;
        end
    end

    assign w_last = w_st[HUE_QB];

    always_comb begin
        w_q    = HUE_W'(w_last.hq);
        w_base = sector_ofs(w_last.sector);
        if (w_last.grey) begin
            n_hue = '0;
        end else if (w_last.neg && (w_base == HUE_OFS_R) && (w_q != '0)) begin
            // negative red sector: wrap into the last part of the turn
            n_hue = HUE_TURN - w_q;
        end else if (w_last.neg) begin
            n_hue = w_base - w_q;
        end else begin
            n_hue = w_base + w_q;
        end
        // black pixel: divisor was zero, force saturation to zero
        n_sat = (w_last.mx == '0) ? '0 : w_last.sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_vld[HUE_QB];
        end
    end

    always_ff @(posedge i_clk) begin
        o_hue        <= n_hue;
        o_saturation <= n_sat;
        o_brightness <= w_last.mx;
    end

    assign o_done = r_done;

endmodule

@@ dv/rgb_to_hsv_convert_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsv_convert: directed corner pixels, then a random stream.
// Depends on rgbhsv_pkg and the rgb_to_hsv_convert RTL; needs no files or arguments.
module testbench;

    import rgbhsv_pkg::*;

    // Fixed-point hue: one 60 degree sector is 3840 units of 1/64 degree.
    localparam int SECTOR_SPAN = 3840;
    localparam int OFS_GREEN   = 7680;
    localparam int OFS_BLUE    = 15360;
    localparam int FULL_TURN   = 23040;

    localparam int RANDOM_PIXELS = 530;
    localparam int DRAIN_CYCLES  = 30;      // quiet time to watch for stray strobes after the drain
    localparam int CYCLE_LIMIT   = 100000;  // hard stop for a hung run

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [7:0]       sat;
        logic [7:0]       val;
    } t_hsv;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [7:0]       i_red = 8'd0;
    logic [7:0]       i_green = 8'd0;
    logic [7:0]       i_blue = 8'd0;
    logic             o_done;
    logic [HUE_W-1:0] o_hue;
    logic [7:0]       o_saturation;
    logic [7:0]       o_brightness;

    t_hsv pending_hsv[$];   // expected results, oldest first
    int   error_count = 0;
    int   pixels_sent = 0;
    int   results_checked = 0;
    int   cycle_count = 0;
    bit   idle_enable = 1'b1;

    rgb_to_hsv_convert i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_done       (o_done),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs or never drains.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_hsv.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Predict one result word: value is the largest channel, saturation the
    // spread scaled by 255/max, hue from the sector of the winning channel.
    function automatic t_hsv hsv_of_pixel(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        int   rr, gg, bb;
        int   top, bottom, spread;
        int   diff, offset, angle;
        t_hsv res;
        rr = int'(r);
        gg = int'(g);
        bb = int'(b);
        top = rr;
        bottom = rr;
        if (gg > top) top = gg;
        if (bb > top) top = bb;
        if (gg < bottom) bottom = gg;
        if (bb < bottom) bottom = bb;
        spread = top - bottom;
        res.sat = (top > 0) ? 8'((spread * 255) / top) : 8'd0;
        angle = 0;
        if (spread > 0) begin
            // Ties go to red first, then green.
            if (rr == top) begin
                diff = gg - bb;
                offset = 0;
            end else if (gg == top) begin
                diff = bb - rr;
                offset = OFS_GREEN;
            end else begin
                diff = rr - gg;
                offset = OFS_BLUE;
            end
            // Signed int division truncates toward zero; wrap negative red-sector hues.
            angle = (SECTOR_SPAN * diff) / spread + offset;
            if (angle < 0) angle += FULL_TURN;
        end
        res.hue = angle[HUE_W-1:0];
        res.val = top[7:0];
        return res;
    endfunction

    // Hand one pixel word to the block. Idle cycle by cycle at random, then
    // hold start until the accepting edge. Start stays high on return so that
    // back-to-back words need no extra assignment.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (idle_enable && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_hsv.push_back(hsv_of_pixel(r, g, b));
        pixels_sent++;
    endtask

    // Drop start and hold off until every expected word has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_hsv.size() != 0);
    endtask

    // Compare each result word with the oldest prediction; the receiver
    // cannot stall, so every strobe must match something already queued.
    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_hsv.size() == 0) begin
                $error("result with nothing expected: hue %0d sat %0d val %0d",
                       o_hue, o_saturation, o_brightness);
                error_count++;
            end else begin
                want = pending_hsv.pop_front();
                results_checked++;
                if (o_hue !== want.hue) begin
                    $error("hue: expected %0d, got %0d", want.hue, o_hue);
                    error_count++;
                end
                if (o_saturation !== want.sat) begin
                    $error("saturation: expected %0d, got %0d", want.sat, o_saturation);
                    error_count++;
                end
                if (o_brightness !== want.val) begin
                    $error("brightness: expected %0d, got %0d", want.val, o_brightness);
                    error_count++;
                end
            end
        end
    end

    // Black, white, greys and primaries, plus the smallest and
    // largest nonzero spreads.
    task automatic test_corner_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd0,   8'd128, 8'd255);
        send_pixel(8'd255, 8'd128, 8'd0);
    endtask

    // Two channels share the maximum: red beats green, green beats blue.
    task automatic test_max_ties();
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd200, 8'd200, 8'd100);
        send_pixel(8'd90,  8'd40,  8'd90);
        send_pixel(8'd3,   8'd7,   8'd7);
    endtask

    // Red sector with blue above green: the hue goes negative and wraps.
    task automatic test_hue_wrap();
        send_pixel(8'd255, 8'd0,  8'd1);
        send_pixel(8'd200, 8'd10, 8'd199);
        send_pixel(8'd2,   8'd0,  8'd1);
    endtask

    // Mix of uniform pixels and shapes that stress the sector and tie logic.
    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
        logic [7:0] corners[5] = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
        logic [7:0] hi, lo;
        int         base;
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            5: begin
                g = r;
                b = r;
            end
            6: begin
                hi = 8'($urandom_range(1, 255));
                lo = 8'($urandom_range(0, hi - 1));
                case ($urandom_range(0, 2))
                    0: begin r = hi; g = hi; b = lo; end
                    1: begin r = lo; g = hi; b = hi; end
                    default: begin r = hi; g = lo; b = hi; end
                endcase
            end
            7: begin
                base = int'($urandom_range(4, 251));
                r = 8'(base + $urandom_range(0, 4) - 2);
                g = 8'(base + $urandom_range(0, 4) - 2);
                b = 8'(base + $urandom_range(0, 4) - 2);
            end
            8: begin
                r = corners[$urandom_range(0, 4)];
                g = corners[$urandom_range(0, 4)];
                b = corners[$urandom_range(0, 4)];
            end
            9: begin
                r = 8'($urandom_range(0, 3));
                g = 8'($urandom_range(0, 3));
                b = 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
    endtask

    // Random stream with a stretch of back-to-back words and a full drain
    // partway through.
    task automatic test_random_stream();
        logic [7:0] r, g, b;
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            idle_enable = !(n >= 150 && n < 300);
            if (n == 400) drain_results();
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_pixels();
        test_max_ties();
        test_hue_wrap();
        drain_results();
        test_random_stream();

        // Let the pipe empty, then watch for stray strobes.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixels: black, white, greys, primaries, max ties, hue wrap,",
                 pixels_sent);
        $display("then a random stream with gaps and a drain; %0d results compared.",
                 results_checked);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
